>>> rtl/mtd_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the motor telemetry decoder.
// Used by mtd_ctrl, mtd_dpath and motor_telemetry_decoder_top; depends on nothing.
package mtd_pkg;

	// Default number of motors served by the block
	localparam int MOTOR_COUNT_DEF = 8;

	// Value slots kept per motor, one per telemetry type
	localparam int TYPE_SLOTS = 8;

	// Quotient bits produced by the period divider, one per iteration
	localparam int DIV_STEPS = 20;

	// Decode constants
	localparam logic [19:0] ERPM_SCALE     = 20'd600000;
	localparam logic [11:0] ERPM_ZERO_CODE = 12'hFFF;
	localparam logic [7:0]  EXT_TYPE_MASK  = 8'hFE;
	localparam logic [15:0] VOLT_SCALE     = 16'd250;
	localparam logic [17:0] CURR_SCALE     = 18'd1000;

	// Configuration port
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 1;
	localparam logic [CFG_INDEX_W-1:0] CFG_TELEMETRY_ENABLE = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_EXTENDED_ALWAYS  = 1'b1;

	// Line status codes
	localparam logic [1:0] LINE_GOOD    = 2'd0;
	localparam logic [1:0] LINE_INVALID = 2'd1;

	// Result status codes
	localparam logic [2:0] STAT_PROCESSED   = 3'd0;
	localparam logic [2:0] STAT_PASSED      = 3'd1;
	localparam logic [2:0] STAT_INVALID     = 3'd2;
	localparam logic [2:0] STAT_NO_EDGE     = 3'd3;
	localparam logic [2:0] STAT_ZERO_PERIOD = 3'd4;

	// Telemetry types
	localparam logic [2:0] TT_ERPM        = 3'd0;
	localparam logic [2:0] TT_TEMPERATURE = 3'd1;
	localparam logic [2:0] TT_VOLTAGE     = 3'd2;
	localparam logic [2:0] TT_CURRENT     = 3'd3;

	// Input item
	typedef struct packed {
		logic [3:0]  motor_index;
		logic [11:0] raw_payload;
		logic [1:0]  line_status;
	} pkt_t;

	// Result item
	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  telem_type;
		logic [19:0] decoded_value;
		logic [11:0] echo_payload;
		logic        sensor_valid;
		logic [19:0] sensor_erpm;
		logic [7:0]  sensor_temperature;
		logic [15:0] sensor_voltage;
		logic [17:0] sensor_current;
		logic [7:0]  max_temperature;
		logic [31:0] good_read_count;
		logic [31:0] bad_packet_count;
	} res_t;

	// Controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_CLASSIFY,
		S_DIVIDE,
		S_COMMIT,
		S_READ,
		S_OUT
	} ctl_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic       load_item;
		logic       div_start;
		logic       div_step;
		logic       commit;
		logic       rd_en;
		logic [2:0] rd_idx;
		logic       load_out;
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic need_div;
		logic need_rd;
	} dp_stat_t;

endpackage

>>> rtl/mtd_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine of the motor telemetry decoder.
// Depends on mtd_pkg; drives the datapath mtd_dpath through dp_cmd_t.
module mtd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pkt_valid,
	output logic              pkt_stall,
	output logic              res_valid,
	input  logic              res_stall,
	input  mtd_pkg::dp_stat_t stat,
	output mtd_pkg::dp_cmd_t  cmd
);

	localparam int STEP_W = $clog2(mtd_pkg::DIV_STEPS);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(mtd_pkg::DIV_STEPS - 1);

	mtd_pkg::ctl_state_t state_q, state_d;
	logic [STEP_W-1:0]   step_q, step_d;
	logic                res_valid_q, res_valid_d;

	// State, step counter and result flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mtd_pkg::S_IDLE;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			step_q      <= step_d;
			res_valid_q <= res_valid_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		step_d    = step_q;
		cmd       = '0;
		pkt_stall = 1'b1;
		case (state_q)
			mtd_pkg::S_IDLE: begin
				pkt_stall = 1'b0;
				if (pkt_valid) begin
					cmd.load_item = 1'b1;
					state_d       = mtd_pkg::S_CLASSIFY;
				end
			end
			mtd_pkg::S_CLASSIFY: begin
				cmd.div_start = 1'b1;
				step_d        = '0;
				state_d       = stat.need_div ? mtd_pkg::S_DIVIDE : mtd_pkg::S_COMMIT;
			end
			mtd_pkg::S_DIVIDE: begin
				cmd.div_step = 1'b1;
				step_d       = step_q + 1'b1;
				if (step_q == STEP_LAST) begin
					state_d = mtd_pkg::S_COMMIT;
				end
			end
			mtd_pkg::S_COMMIT: begin
				cmd.commit = 1'b1;
				step_d     = '0;
				state_d    = stat.need_rd ? mtd_pkg::S_READ : mtd_pkg::S_OUT;
			end
			mtd_pkg::S_READ: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_idx = step_q[2:0];
				step_d     = step_q + 1'b1;
				if (step_q[2:0] == mtd_pkg::TT_CURRENT) begin
					state_d = mtd_pkg::S_OUT;
				end
			end
			mtd_pkg::S_OUT: begin
				// Load the result register once it is free or being drained
				if (!res_valid_q || !res_stall) begin
					cmd.load_out = 1'b1;
					state_d      = mtd_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mtd_pkg::S_IDLE;
			end
		endcase
	end

	// Hold the result until taken
	always_comb begin
		if (cmd.load_out) begin
			res_valid_d = 1'b1;
		end else begin
			res_valid_d = res_valid_q && res_stall;
		end
	end

	assign res_valid = res_valid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_stall |-> !cmd.load_out)
		else $error("result register overwritten while stalled");

	a_accept_classify: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_valid && !pkt_stall |=> state_q == mtd_pkg::S_CLASSIFY)
		else $error("accepted item not classified next cycle");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mtd_pkg::S_DIVIDE && step_q == STEP_LAST |=> state_q == mtd_pkg::S_COMMIT)
		else $error("divider did not finish after its last step");

	a_read_needed: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> stat.need_rd)
		else $error("value memory read for an item that reports no sensor data");

endmodule

>>> rtl/mtd_dpath.sv
`timescale 1ns / 1ps
// Datapath of the motor telemetry decoder: item register, decode, serial
// period divider, per-motor state, value memory and result register. Depends on mtd_pkg.
module mtd_dpath #(
	parameter int MOTOR_COUNT = mtd_pkg::MOTOR_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mtd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mtd_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  mtd_pkg::pkt_t                   pkt,
	input  mtd_pkg::dp_cmd_t                cmd,
	output mtd_pkg::dp_stat_t               stat,
	output mtd_pkg::res_t                   res
);

	localparam int MI_W      = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
	localparam int MEM_DEPTH = MOTOR_COUNT * mtd_pkg::TYPE_SLOTS;
	localparam int AW        = MI_W + 3;

	// Configuration
	logic en_q, ext_q;

	// Captured item
	mtd_pkg::pkt_t item_q;

	// Per-motor state
	logic [7:0]  seen_q [MOTOR_COUNT];
	logic [7:0]  peak_q [MOTOR_COUNT];
	logic [19:0] value_mem_q [MEM_DEPTH];
	logic [31:0] good_q, bad_q;

	// Divider
	logic [19:0] div_num_q;
	logic [15:0] div_rem_q;
	logic [15:0] div_den_q;

	// Per-item results and sensor reads
	logic [2:0]  st_q, ttype_q;
	logic [19:0] dec_q;
	logic [19:0] erpm_q;
	logic [7:0]  temp_q, volt_q, curr_q;
	mtd_pkg::res_t res_q;

	// Decode signals
	logic [MI_W-1:0] mot;
	logic            in_range, proc, ext_frame;
	logic [3:0]      nib;
	logic [15:0]     period;
	logic [2:0]      status_c, ttype_c;
	logic [19:0]     dec_c, dec_fin;
	logic [AW-1:0]   wr_addr, rd_addr;
	logic [16:0]     trial, diff;
	logic            ge;
	logic [7:0]      seen_m, peak_m;

	assign mot      = item_q.motor_index[MI_W-1:0];
	assign in_range = {1'b0, item_q.motor_index} < 5'(MOTOR_COUNT);
	assign proc     = en_q && in_range;
	assign nib      = item_q.raw_payload[11:8];
	assign period   = 16'(item_q.raw_payload[8:0]) << item_q.raw_payload[11:9];
	assign seen_m   = in_range ? seen_q[mot] : 8'd0;
	assign peak_m   = in_range ? peak_q[mot] : 8'd0;

	// Classify the captured item
	always_comb begin
		ext_frame     = (ext_q || ((seen_m & mtd_pkg::EXT_TYPE_MASK) != 8'd0)) &&
		                !nib[0] && (nib != 4'd0);
		status_c      = mtd_pkg::STAT_PASSED;
		ttype_c       = mtd_pkg::TT_ERPM;
		dec_c         = '0;
		stat.need_div = 1'b0;
		stat.need_rd  = proc;
		if (proc) begin
			if (item_q.line_status == mtd_pkg::LINE_GOOD) begin
				status_c = mtd_pkg::STAT_PROCESSED;
				if (ext_frame) begin
					ttype_c = nib[3:1];
					dec_c   = 20'(item_q.raw_payload[7:0]);
				end else if (item_q.raw_payload != mtd_pkg::ERPM_ZERO_CODE) begin
					if (item_q.raw_payload[8:0] == 9'd0) begin
						status_c = mtd_pkg::STAT_ZERO_PERIOD;
					end else begin
						stat.need_div = 1'b1;
					end
				end
			end else if (item_q.line_status == mtd_pkg::LINE_INVALID) begin
				status_c = mtd_pkg::STAT_INVALID;
			end else begin
				status_c = mtd_pkg::STAT_NO_EDGE;
			end
		end
	end

	assign dec_fin = stat.need_div ? div_num_q : dec_c;
	assign wr_addr = {mot, ttype_c};
	assign rd_addr = {mot, cmd.rd_idx};

	// Restoring divider step: one quotient bit per cycle
	assign trial = {div_rem_q, div_num_q[19]};
	assign ge    = trial >= {1'b0, div_den_q};
	assign diff  = trial - {1'b0, div_den_q};

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q  <= 1'b0;
			ext_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				mtd_pkg::CFG_TELEMETRY_ENABLE: en_q  <= cfg_data[0];
				mtd_pkg::CFG_EXTENDED_ALWAYS:  ext_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Capture item
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= pkt;
		end
	end

	// Load and advance the divider
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_num_q <= mtd_pkg::ERPM_SCALE + 20'(period >> 1);
			div_rem_q <= '0;
			div_den_q <= period;
		end else if (cmd.div_step) begin
			div_num_q <= {div_num_q[18:0], ge};
			div_rem_q <= ge ? diff[15:0] : trial[15:0];
		end
	end

	// Commit per-motor state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MOTOR_COUNT; i++) begin
				seen_q[i] <= '0;
				peak_q[i] <= '0;
			end
			good_q <= '0;
			bad_q  <= '0;
		end else if (cmd.commit) begin
			if (status_c == mtd_pkg::STAT_PROCESSED ||
			    status_c == mtd_pkg::STAT_ZERO_PERIOD) begin
				good_q <= good_q + 32'd1;
			end
			if (status_c == mtd_pkg::STAT_INVALID ||
			    status_c == mtd_pkg::STAT_ZERO_PERIOD) begin
				bad_q <= bad_q + 32'd1;
			end
			if (status_c == mtd_pkg::STAT_PROCESSED) begin
				seen_q[mot] <= seen_q[mot] | (8'd1 << ttype_c);
				if (ttype_c == mtd_pkg::TT_TEMPERATURE && dec_fin[7:0] > peak_q[mot]) begin
					peak_q[mot] <= dec_fin[7:0];
				end
			end
		end
	end

	// Latch the item's result fields
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			st_q    <= status_c;
			ttype_q <= ttype_c;
			dec_q   <= dec_fin;
		end
	end

	// Value memory: write on commit, read one slot per cycle
	always_ff @(posedge clk) begin
		if (cmd.commit && status_c == mtd_pkg::STAT_PROCESSED) begin
			value_mem_q[wr_addr] <= dec_fin;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			case (cmd.rd_idx)
				mtd_pkg::TT_ERPM:        erpm_q <= value_mem_q[rd_addr];
				mtd_pkg::TT_TEMPERATURE: temp_q <= value_mem_q[rd_addr][7:0];
				mtd_pkg::TT_VOLTAGE:     volt_q <= value_mem_q[rd_addr][7:0];
				mtd_pkg::TT_CURRENT:     curr_q <= value_mem_q[rd_addr][7:0];
				default: begin
				end
			endcase
		end
	end

	// Assemble the result item
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_q.status             <= st_q;
			res_q.telem_type         <= ttype_q;
			res_q.decoded_value      <= dec_q;
			res_q.echo_payload       <= item_q.raw_payload;
			res_q.max_temperature    <= peak_m;
			res_q.good_read_count    <= good_q;
			res_q.bad_packet_count   <= bad_q;
			res_q.sensor_valid       <= 1'b0;
			res_q.sensor_erpm        <= '0;
			res_q.sensor_temperature <= '0;
			res_q.sensor_voltage     <= '0;
			res_q.sensor_current     <= '0;
			if (proc && seen_m[0]) begin
				res_q.sensor_valid <= 1'b1;
				res_q.sensor_erpm  <= erpm_q;
				if (seen_m[1]) begin
					res_q.sensor_temperature <= temp_q;
				end
				if (seen_m[2]) begin
					res_q.sensor_voltage <= 16'(volt_q) * mtd_pkg::VOLT_SCALE;
				end
				if (seen_m[3]) begin
					res_q.sensor_current <= 18'(curr_q) * mtd_pkg::CURR_SCALE;
				end
			end
		end
	end

	assign res = res_q;

endmodule

>>> rtl/motor_telemetry_decoder_top.sv
`timescale 1ns / 1ps
// Top level of the motor telemetry decoder: controller plus datapath.
// Depends on mtd_pkg, mtd_ctrl and mtd_dpath.
//
//   channel  handshake                 payload
//   -------  ------------------------  -------------------------------
//   pkt      pkt_valid / pkt_stall     pkt  (mtd_pkg::pkt_t)
//   res      res_valid / res_stall     res  (mtd_pkg::res_t)
//   cfg      cfg_we                    cfg_index, cfg_data
//
// An item passes through the idle, classify, commit and output states before
// its successor can be accepted; with telemetry enabled and the motor in range
// it also passes the read states; an eRPM divide adds 20 divider iterations.
// Sensor values come out of the value memory one slot per cycle.
// Reset clears the per-motor seen flags and peak temperatures at once; there is no clearing pass.
// A stalled result holds in the result register; the next item is accepted
// meanwhile but waits at the end of its work until the register frees.
module motor_telemetry_decoder_top #(
	parameter int MOTOR_COUNT = mtd_pkg::MOTOR_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mtd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mtd_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            pkt_valid,
	output logic                            pkt_stall,
	input  mtd_pkg::pkt_t                   pkt,
	output logic                            res_valid,
	input  logic                            res_stall,
	output mtd_pkg::res_t                   res
);

	mtd_pkg::dp_cmd_t  cmd;
	mtd_pkg::dp_stat_t stat;

	// Sequencer
	mtd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt_valid),
		.pkt_stall (pkt_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Decode, divide and per-motor state
	mtd_dpath #(
		.MOTOR_COUNT (MOTOR_COUNT)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pkt       (pkt),
		.cmd       (cmd),
		.stat      (stat),
		.res       (res)
	);

endmodule
